// ===== design/u8u16_pkg.sv =====
package u8u16_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_TOO_FEW = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // One decoded transaction from the front: a single result, or the high half
  // of a surrogate pair in res plus the low half in low_unit.
  typedef struct packed {
    logic        pair;
    out_item_t   res;
    logic [15:0] low_unit;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [7:0] AsciiEnd    = 8'h80;
  localparam logic [7:0] LeadMin     = 8'hc2;
  localparam logic [7:0] Lead3Min    = 8'he0;
  localparam logic [7:0] Lead4Min    = 8'hf0;
  localparam logic [7:0] LeadEnd     = 8'hf8;
  localparam logic [7:0] Lead3NoOvl  = 8'he1;
  localparam logic [7:0] Lead3Surr   = 8'hed;
  localparam logic [7:0] Lead4NoOvl  = 8'hf1;
  localparam logic [7:0] Lead4Max    = 8'hf4;
  localparam logic [7:0] Cont3Split  = 8'ha0;
  localparam logic [7:0] Cont4Split  = 8'h90;
  localparam logic [20:0] SuppBase   = 21'h10000;
  localparam logic [5:0] HighSurrTag = 6'b110110;
  localparam logic [5:0] LowSurrTag  = 6'b110111;

  function automatic logic is_cont(input logic [7:0] x);
    return x[7:6] == 2'b10;
  endfunction

endpackage

// ===== design/u8u16_front.sv =====
module u8u16_front import u8u16_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output logic     emit,
  output q_entry_t entry
);

  logic [7:0] lead_r, lead_nxt;
  logic [7:0] held_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] need_r, need_nxt;
  logic       skip_r, skip_nxt;
  status_t    saved_r, saved_nxt;
  logic       held_we;

  logic [7:0]  b, c, b1, b2;
  logic        eos;
  logic        ok2, ok3, ok;
  logic [15:0] unit2;
  logic [9:0]  unit3;
  logic [20:0] cp4;
  logic [19:0] off4;

  assign b   = item.byte_in;
  assign eos = item.end_of_string;
  assign c   = lead_r;
  assign b1  = held_r[0];
  assign b2  = held_r[1];

  assign ok2 = is_cont(b1) && is_cont(b) && (c >= Lead3NoOvl || b1 >= Cont3Split)
               && (c != Lead3Surr || b1 < Cont3Split);
  assign ok3 = is_cont(b1) && is_cont(b2) && is_cont(b)
               && (c >= Lead4NoOvl || b1 >= Cont4Split)
               && (c < Lead4Max || (c == Lead4Max && b1 < Cont4Split));
  assign unit2 = {c[3:0], b1[5:0], b[5:0]};
  assign cp4   = {c[2:0], b1[5:0], b2[5:0], b[5:0]};
  assign off4  = 20'(cp4 - SuppBase);
  assign unit3 = off4[19:10];

  always_comb begin
    lead_nxt  = lead_r;
    cnt_nxt   = cnt_r;
    need_nxt  = need_r;
    skip_nxt  = skip_r;
    saved_nxt = saved_r;
    held_we   = 1'b0;
    emit      = 1'b0;
    ok        = 1'b1;
    entry     = '0;
    entry.res.status = ST_OK;
    entry.res.last   = eos;

    if (skip_r) begin
      if (eos) begin
        emit             = 1'b1;
        entry.res.status = saved_r;
        skip_nxt         = 1'b0;
        saved_nxt        = ST_OK;
      end
    end else if (need_r == 2'd0) begin
      if (b < AsciiEnd) begin
        emit                 = 1'b1;
        entry.res.code_unit  = {8'd0, b};
        entry.res.unit_valid = 1'b1;
      end else if (b < LeadMin || b >= LeadEnd) begin
        ok = 1'b0;
      end else begin
        lead_nxt = b;
        need_nxt = (b < Lead3Min) ? 2'd1 : ((b < Lead4Min) ? 2'd2 : 2'd3);
        cnt_nxt  = 2'd0;
        if (eos) begin
          emit             = 1'b1;
          entry.res.status = ST_TOO_FEW;
          need_nxt         = 2'd0;
        end
      end
    end else if (3'(cnt_r) + 3'd1 < 3'(need_r)) begin
      held_we = 1'b1;
      cnt_nxt = cnt_r + 2'd1;
      if (eos) begin
        emit             = 1'b1;
        entry.res.status = ST_TOO_FEW;
        need_nxt         = 2'd0;
        cnt_nxt          = 2'd0;
      end
    end else begin
      // Sequence complete: check and convert
      need_nxt = 2'd0;
      cnt_nxt  = 2'd0;
      case (need_r)
        2'd1: begin
          ok = is_cont(b);
          entry.res.code_unit = {5'd0, c[4:0], b[5:0]};
        end
        2'd2: begin
          ok = ok2;
          entry.res.code_unit = unit2;
        end
        default: begin
          ok = ok3;
          entry.pair          = 1'b1;
          entry.res.code_unit = {HighSurrTag, unit3};
          entry.low_unit      = {LowSurrTag, off4[9:0]};
        end
      endcase
      if (ok) begin
        emit                 = 1'b1;
        entry.res.unit_valid = 1'b1;
      end
    end

    if (!ok) begin
      entry = '0;
      need_nxt = 2'd0;
      cnt_nxt  = 2'd0;
      if (eos) begin
        emit             = 1'b1;
        entry.res.status = ST_ILLEGAL;
        entry.res.last   = 1'b1;
      end else begin
        skip_nxt  = 1'b1;
        saved_nxt = ST_ILLEGAL;
      end
    end

    // Any end of string returns to idle
    if (eos) begin
      need_nxt  = 2'd0;
      cnt_nxt   = 2'd0;
      skip_nxt  = 1'b0;
      saved_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r  <= '0;
      cnt_r   <= '0;
      need_r  <= '0;
      skip_r  <= 1'b0;
      saved_r <= ST_OK;
    end else if (accept) begin
      lead_r  <= lead_nxt;
      cnt_r   <= cnt_nxt;
      need_r  <= need_nxt;
      skip_r  <= skip_nxt;
      saved_r <= saved_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held_r[cnt_r[0]] <= b;
    end
  end

endmodule

// ===== design/u8u16_queue.sv =====
module u8u16_queue import u8u16_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_data,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t stat
);

  q_entry_t       mem_r [QDepth];
  logic [QAw-1:0] wr_r, rd_r;
  logic [QAw:0]   cnt_r;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (QAw+1)'(QDepth));
  assign head       = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (QAw+1)'(push) - (QAw+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

// ===== design/u8u16_back.sv =====
module u8u16_back import u8u16_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_entry_t  head,
  input  q_status_t qstat,
  output logic      deq,
  output out_item_t res,
  output logic      res_valid,
  input  logic      res_take
);

  out_item_t res_r, res_nxt;
  logic      valid_r, valid_nxt;
  logic      phase_r, phase_nxt;
  logic      load;

  assign load = !valid_r || res_take;

  always_comb begin
    res_nxt   = res_r;
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    deq       = 1'b0;
    if (load) begin
      if (phase_r) begin
        // Send the low half of the surrogate pair, then retire the entry
        res_nxt.code_unit  = head.low_unit;
        res_nxt.unit_valid = 1'b1;
        res_nxt.status     = ST_OK;
        res_nxt.last       = head.res.last;
        valid_nxt          = 1'b1;
        phase_nxt          = 1'b0;
        deq                = 1'b1;
      end else if (!qstat.empty) begin
        res_nxt   = head.res;
        valid_nxt = 1'b1;
        if (head.pair) begin
          res_nxt.last = 1'b0;
          phase_nxt    = 1'b1;
        end else begin
          deq = 1'b1;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res       = res_r;
  assign res_valid = valid_r;

endmodule

// ===== design/utf8_to_utf16_decoder_unit.sv =====
// UTF-8 to UTF-16 decoder. Takes one byte per clock while in_full is low; a
// byte is decoded in the cycle it is accepted and its results go into a
// four-entry queue. The result side delivers one UTF-16 unit per clock while
// out_pop takes each one, so a four-byte sequence (surrogate pair) gives two
// units on out_data; sustained input is one byte per cycle unless out_pop
// stalls, when in_full rises once the queue fills. Results pass through the
// queue and the output register before they reach out_data. Bad sequences
// give a status-only result (unit_valid low) at string end, with last set.
module utf8_to_utf16_decoder_unit import u8u16_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_data,
  output logic      in_full,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic      accept;
  logic      emit;
  q_entry_t  entry;
  q_entry_t  head;
  q_status_t qstat;
  logic      deq;
  logic      res_valid;

  assign in_full = qstat.full;
  assign accept  = in_push && !qstat.full;

  u8u16_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .emit   (emit),
    .entry  (entry)
  );

  u8u16_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && emit),
    .push_data (entry),
    .pop       (deq),
    .head      (head),
    .stat      (qstat)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .deq       (deq),
    .res       (out_data),
    .res_valid (res_valid),
    .res_take  (out_pop && res_valid)
  );

  assign out_empty = !res_valid;

endmodule
